/* rtl/ctnf_pkg.sv */
// shared types and constants for the closest tone neighbor filter
`timescale 1ns / 1ps

package ctnf_pkg;

  localparam int PIX_W = 8;
  localparam int DIM_W = 12;
  localparam int CFG_IDX_W = 1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] pixel_in;
  } ctnf_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_last;
  } ctnf_out_t;

endpackage

/* rtl/closest_tone_neighbor_filter_unit.sv */
// top level of the closest tone neighbor filter with line stores and 3x3 window
`timescale 1ns / 1ps

// Closest tone neighbor filter. Pixels enter in raster order, one transaction per
// clock; each interior pixel leaves as the neighbor nearest to it in value, border
// pixels leave unchanged, and the output for a pixel appears frame_width+1 input
// transactions later. The frame tail is pushed out by drain transactions (kind = 1)
// or by the next frame's first pixels. An accepted transaction is registered in
// the window stage together with its line store reads and then, when the output
// register is free or draining, in the output register; throughput is one
// transaction per clock, bounded only by out_ready. Each line store has one write
// port and two read ports, one for the window column and one for the tail.
// Configuration writes must be made only while the block holds no transaction.
module closest_tone_neighbor_filter_unit #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ctnf_pkg::ctnf_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ctnf_pkg::ctnf_out_t                 out_data,
  input  logic                                cfg_we,
  input  logic [ctnf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ctnf_pkg::DIM_W-1:0]          cfg_wdata
);

  import ctnf_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int PW = $clog2(MAX_WIDTH + 2);

  typedef enum logic [1:0] {
    SRC_TAIL    = 2'd0,
    SRC_WIN     = 2'd1,
    SRC_CLOSEST = 2'd2
  } src_t;

  typedef struct packed {
    logic pix_item;
    logic have;
    logic last;
    src_t src;
    logic t_upper;
    logic fwd_c;
    logic fwd_t;
  } s1_ctl_t;

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

  logic [DIM_W-1:0] width_r, height_r;
  logic [AW-1:0]    col_r, col_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;
  logic [PW-1:0]    pend_r, pend_nxt;

  logic [PIX_W-1:0] win_r [3][3];
  logic [PIX_W-1:0] nw [3][3];

  logic             s1_v_r;
  s1_ctl_t          s1_r, s1_nxt;
  logic [AW-1:0]    s1_c_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [PIX_W-1:0] up_rd_r, mid_rd_r, up_t_rd_r, mid_t_rd_r;
  logic [PIX_W-1:0] fwd_up_r, fwd_mid_r, fwd_t_r;

  logic             out_valid_r;
  ctnf_out_t        out_data_r;

  logic             in_fire, adv, is_pix;
  logic [31:0]      fw32;
  logic [WW-1:0]    eff_w, wm1;
  logic [DIM_W-1:0] eff_h;
  logic [AW-1:0]    c_sat, j_addr;
  logic [DIM_W-1:0] r_sat;
  logic             h_ge2, pend_nz, pend_one, col_last, row_last, frame_done;
  logic [PW-1:0]    total, k, jk, jc;
  logic             moved, t_upper;

  logic [PIX_W-1:0] up_eff, mid_eff, tail_val, close_val, res_val;

  // geometry and position of the incoming transaction
  always_comb begin
    fw32 = 32'(width_r);
    if (fw32 == 32'd0) begin
      eff_w = WW'(1);
    end else if (fw32 > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_r);
    end
    wm1   = eff_w - WW'(1);
    eff_h = (height_r == '0) ? DIM_W'(1) : height_r;
    c_sat = (WW'(col_r) >= eff_w) ? AW'(wm1) : col_r;
    r_sat = (row_r >= eff_h) ? eff_h - DIM_W'(1) : row_r;
    h_ge2 = (eff_h >= DIM_W'(2));
    total = PW'(eff_w) + (h_ge2 ? PW'(1) : PW'(0));
    k     = (pend_r <= total) ? total - pend_r : '0;
    jk    = h_ge2 ? k - PW'(1) : k;
    jc    = (jk >= PW'(eff_w)) ? PW'(wm1) : jk;
    if (h_ge2 && k == '0) begin
      j_addr  = AW'(wm1);
      moved   = 1'b1;
    end else begin
      j_addr  = AW'(jc);
      moved   = (r_sat != '0) || (AW'(jc) < c_sat);
    end
    t_upper  = moved;
    pend_nz  = (pend_r != '0);
    pend_one = (pend_r == PW'(1));
    is_pix   = !in_data.kind;
    col_last = (WW'(c_sat) == wm1);
    row_last = (r_sat == eff_h - DIM_W'(1));
    frame_done = is_pix && col_last && row_last;
  end

  // counters and control for the window stage
  always_comb begin
    col_nxt = c_sat;
    row_nxt = r_sat;
    if (is_pix) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : r_sat + DIM_W'(1);
      end else begin
        col_nxt = c_sat + AW'(1);
      end
    end
    if (frame_done) begin
      pend_nxt = total;
    end else if (pend_nz) begin
      pend_nxt = pend_r - PW'(1);
    end else begin
      pend_nxt = pend_r;
    end

    s1_nxt          = '0;
    s1_nxt.pix_item = is_pix;
    s1_nxt.t_upper  = t_upper;
    s1_nxt.src      = SRC_TAIL;
    s1_nxt.fwd_c    = s1_v_r && s1_r.pix_item && (s1_c_r == c_sat);
    s1_nxt.fwd_t    = s1_v_r && s1_r.pix_item && (s1_c_r == j_addr);
    if (pend_nz) begin
      s1_nxt.have = 1'b1;
      s1_nxt.last = pend_one;
    end else if (is_pix && c_sat == '0 && r_sat >= DIM_W'(2)) begin
      s1_nxt.have = 1'b1;
      s1_nxt.src  = SRC_WIN;
    end else if (is_pix && c_sat != '0 && r_sat != '0) begin
      s1_nxt.have = 1'b1;
      s1_nxt.src  = (r_sat >= DIM_W'(2) && c_sat >= AW'(2)) ? SRC_CLOSEST : SRC_WIN;
    end
  end

  assign adv      = s1_v_r && (!s1_r.have || !out_valid_r || out_ready);
  assign in_ready = !s1_v_r || adv;
  assign in_fire  = in_valid && in_ready;

  // window stage
  assign up_eff   = s1_r.fwd_c ? fwd_up_r : up_rd_r;
  assign mid_eff  = s1_r.fwd_c ? fwd_mid_r : mid_rd_r;
  assign tail_val = s1_r.fwd_t ? fwd_t_r : (s1_r.t_upper ? up_t_rd_r : mid_t_rd_r);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nw[i][0] = win_r[i][1];
      nw[i][1] = win_r[i][2];
    end
    nw[0][2] = up_eff;
    nw[1][2] = mid_eff;
    nw[2][2] = s1_pix_r;
  end

  function automatic logic [2*PIX_W-1:0] pick(input logic [2*PIX_W-1:0] a,
                                              input logic [2*PIX_W-1:0] b);
    // upper half is the difference, left operand wins ties
    return (a[2*PIX_W-1:PIX_W] <= b[2*PIX_W-1:PIX_W]) ? a : b;
  endfunction

  always_comb begin
    logic [PIX_W-1:0]   nb [8];
    logic [2*PIX_W-1:0] lv1 [4];
    logic [2*PIX_W-1:0] lv2 [2];
    logic [2*PIX_W-1:0] dv [8];
    logic [2*PIX_W-1:0] top;
    nb[0] = nw[0][0];
    nb[1] = nw[0][1];
    nb[2] = nw[0][2];
    nb[3] = nw[1][0];
    nb[4] = nw[1][2];
    nb[5] = nw[2][0];
    nb[6] = nw[2][1];
    nb[7] = nw[2][2];
    for (int i = 0; i < 8; i++) begin
      dv[i] = {((nw[1][1] >= nb[i]) ? nw[1][1] - nb[i] : nb[i] - nw[1][1]), nb[i]};
    end
    for (int i = 0; i < 4; i++) begin
      lv1[i] = pick(dv[2*i], dv[2*i+1]);
    end
    lv2[0] = pick(lv1[0], lv1[1]);
    lv2[1] = pick(lv1[2], lv1[3]);
    top = pick(lv2[0], lv2[1]);
    close_val = top[PIX_W-1:0];
  end

  always_comb begin
    unique case (s1_r.src)
      SRC_TAIL:    res_val = tail_val;
      SRC_WIN:     res_val = win_r[1][2];
      SRC_CLOSEST: res_val = close_val;
      default:     res_val = tail_val;
    endcase
  end

  // line stores
  always_ff @(posedge clk) begin
    if (adv && s1_r.pix_item) begin
      upper_mem[s1_c_r] <= mid_eff;
    end
    if (in_fire) begin
      up_rd_r   <= upper_mem[c_sat];
      up_t_rd_r <= upper_mem[j_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_r.pix_item) begin
      middle_mem[s1_c_r] <= s1_pix_r;
    end
    if (in_fire) begin
      mid_rd_r   <= middle_mem[c_sat];
      mid_t_rd_r <= middle_mem[j_addr];
    end
  end

  // stage payload and bypass of the write made on the same edge
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_c_r    <= c_sat;
      s1_pix_r  <= in_data.pixel_in;
      fwd_up_r  <= mid_eff;
      fwd_mid_r <= s1_pix_r;
      fwd_t_r   <= t_upper ? mid_eff : s1_pix_r;
    end
    if (adv && s1_r.have) begin
      out_data_r.pixel_out  <= res_val;
      out_data_r.frame_last <= s1_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= WIDTH_RESET;
      height_r    <= HEIGHT_RESET;
      col_r       <= '0;
      row_r       <= '0;
      pend_r      <= '0;
      s1_v_r      <= 1'b0;
      s1_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FRAME_WIDTH:  width_r  <= cfg_wdata;
          CFG_FRAME_HEIGHT: height_r <= cfg_wdata;
          default:          width_r  <= width_r;
        endcase
      end
      if (in_fire) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        pend_r <= pend_nxt;
        s1_r   <= s1_nxt;
        s1_v_r <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv && s1_r.pix_item) begin
        win_r <= nw;
      end
      if (adv && s1_r.have) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/ctnf_checker.sv */
// port level checks for the closest tone neighbor filter and their bind
`timescale 1ns / 1ps

module ctnf_assertions (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input ctnf_pkg::ctnf_in_t         in_data,
  input logic                       out_valid,
  input logic                       out_ready,
  input ctnf_pkg::ctnf_out_t        out_data
);

  import ctnf_pkg::*;

  // a waiting input transaction holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input changed while waiting");

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

  // a free or draining output never blocks the input
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input blocked while output can move");

endmodule

bind closest_tone_neighbor_filter_unit ctnf_assertions u_ctnf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
